// ===== hdl/polymul_pkg.sv =====
// ----------------------------------------------------------------------------
// polymul_pkg
// Shared types and constants for the polynomial multiplier.
// ----------------------------------------------------------------------------
package polymul_pkg;

  // Width of a coefficient word and of a term degree
  localparam int unsigned COEFF_W = 32;
  localparam int unsigned POW_W   = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [POW_W-1:0] wr_addr;
    logic             mac_en;
    logic [POW_W-1:0] addr_a;
    logic [POW_W-1:0] addr_b;
    logic             mac_first;
    logic             mac_last;
    logic [POW_W-1:0] mac_pow;
    logic             clr_any;
    logic             res_rd;
    logic [POW_W-1:0] res_addr;
    logic             out_load;
    logic [POW_W-1:0] out_pow;
    logic             out_final;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic busy;
    logic any;
  } status_t;

endpackage

// ===== hdl/polynomial_multiply.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply
// Product of two polynomials with signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Load the first polynomial, then the second, one coefficient word per cycle,
// lowest degree first, each closed by last. Coefficients past MAX_TERMS are
// dropped. After the second last word the input stalls while a single
// multiply-accumulate unit walks the convolution, one product per cycle for
// the N1*N2 products of operands of N1 and N2 terms, and drains its pipeline.
// Then the N1+N2-1 product words go out lowest degree first, each held while
// the output stalls; an all-zero product gives one zero word of degree 0.
// Each sum is exact, rounded to FRAC_BITS fraction bits (nearest, ties up)
// and clipped to 32 bits with the saturated flag.
module polynomial_multiply import polymul_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operand_i,
  input  logic signed [COEFF_W-1:0] coeff_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COEFF_W-1:0] product_coeff_o,
  output logic [POW_W-1:0]          power_o,
  output logic                      saturated_o,
  output logic                      final_res_o
);

  cmd_t    cmd;
  status_t status;

  polymul_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operand_i   (operand_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  polymul_dp #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coeff_i         (coeff_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .product_coeff_o (product_coeff_o),
    .power_o         (power_o),
    .saturated_o     (saturated_o),
    .final_res_o     (final_res_o)
  );

endmodule

// ===== hdl/polymul_dp.sv =====
// ----------------------------------------------------------------------------
// polymul_dp
// Coefficient stores, multiply-accumulate pipeline, rounding and saturation,
// result store and output register.
// ----------------------------------------------------------------------------
module polymul_dp import polymul_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [COEFF_W-1:0] coeff_i,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  output logic signed [COEFF_W-1:0] product_coeff_o,
  output logic [POW_W-1:0]          power_o,
  output logic                      saturated_o,
  output logic                      final_res_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_TERMS);
  localparam int unsigned PROD_N = 2 * MAX_TERMS - 1;
  localparam int unsigned RES_AW = $clog2(PROD_N);
  localparam int unsigned MUL_W  = 2 * COEFF_W;
  localparam int unsigned ACC_W  = MUL_W + $clog2(MAX_TERMS) + 1;
  localparam int unsigned RND_W  = ACC_W + 1;
  localparam logic [RND_W-1:0] HALF = RND_W'(2 ** FRAC_BITS) >> 1;

  logic [COEFF_W-1:0] mem_a [MAX_TERMS];
  logic [COEFF_W-1:0] mem_b [MAX_TERMS];
  logic [COEFF_W:0]   mem_r [PROD_N];

  logic signed [COEFF_W-1:0] a_q, b_q;
  logic signed [MUL_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      s1_valid_q, s1_first_q, s1_last_q;
  logic                      s2_valid_q, s2_first_q, s2_last_q;
  logic [POW_W-1:0]          s1_pow_q, s2_pow_q, fin_pow_q;
  logic                      fin_valid_q;
  logic                      any_q;
  logic [COEFF_W:0]          rd_data_q;

  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   shifted;
  logic [RND_W-COEFF_W:0]    hi_bits;
  logic                      in_range;
  logic [COEFF_W-1:0]        nar_val;
  logic                      nar_sat;

  // Operand stores and their read stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[cmd_i.wr_addr[IDX_W-1:0]] <= coeff_i;
    end
    if (cmd_i.wr_b) begin
      mem_b[cmd_i.wr_addr[IDX_W-1:0]] <= coeff_i;
    end
    if (cmd_i.mac_en) begin
      a_q <= mem_a[cmd_i.addr_a[IDX_W-1:0]];
      b_q <= mem_b[cmd_i.addr_b[IDX_W-1:0]];
    end
  end

  // Multiply and accumulate payload
  always_comb begin
    acc_d = (s2_first_q ? '0 : acc_q) + {{(ACC_W-MUL_W){prod_q[MUL_W-1]}}, prod_q};
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.mac_first;
    s1_last_q  <= cmd_i.mac_last;
    s1_pow_q   <= cmd_i.mac_pow;
    prod_q     <= a_q * b_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_pow_q   <= s1_pow_q;
    fin_pow_q  <= s2_pow_q;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.mac_en;
      s2_valid_q  <= s1_valid_q;
      fin_valid_q <= s2_valid_q & s2_last_q;
    end
  end

  // Round to nearest (ties up), drop fraction bits, clip to a word
  always_comb begin
    rnd      = {acc_q[ACC_W-1], acc_q} + HALF;
    shifted  = rnd >>> FRAC_BITS;
    hi_bits  = shifted[RND_W-1:COEFF_W-1];
    in_range = (&hi_bits) | ~(|hi_bits);
    nar_sat  = ~in_range;
    if (in_range) begin
      nar_val = shifted[COEFF_W-1:0];
    end else if (shifted[RND_W-1]) begin
      nar_val = {1'b1, {(COEFF_W-1){1'b0}}};
    end else begin
      nar_val = {1'b0, {(COEFF_W-1){1'b1}}};
    end
  end

  // Result store
  always_ff @(posedge clk_i) begin
    if (fin_valid_q) begin
      mem_r[fin_pow_q[RES_AW-1:0]] <= {nar_sat, nar_val};
    end
    if (cmd_i.res_rd) begin
      rd_data_q <= mem_r[cmd_i.res_addr[RES_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (cmd_i.clr_any) begin
      any_q <= 1'b0;
    end else if (fin_valid_q && nar_val != '0) begin
      any_q <= 1'b1;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      product_coeff_o <= rd_data_q[COEFF_W-1:0];
      saturated_o     <= rd_data_q[COEFF_W];
      power_o         <= cmd_i.out_pow;
      final_res_o     <= cmd_i.out_final;
    end
  end

  assign status_o.busy = s1_valid_q | s2_valid_q | fin_valid_q;
  assign status_o.any  = any_q;

endmodule

// ===== hdl/polymul_ctrl.sv =====
// ----------------------------------------------------------------------------
// polymul_ctrl
// Sequencer: operand loading, convolution index walk, drain and emission.
// ----------------------------------------------------------------------------
module polymul_ctrl import polymul_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    operand_i,
  input  logic    last_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_MAC     = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_EMIT_RD = 6'b001000,
    S_EMIT_LD = 6'b010000,
    S_EMIT_WT = 6'b100000
  } state_e;

  localparam logic [POW_W-1:0] MAX_CNT = POW_W'(MAX_TERMS);

  state_e           state_q, state_d;
  logic [POW_W-1:0] fc_q, fc_d, sc_q, sc_d;
  logic             closed_q, closed_d;
  logic [POW_W-1:0] k_q, k_d, i_q, i_d, e_q, e_d, elast_q, elast_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc;
  logic [POW_W-1:0] i_hi, k_max, k_nxt, i_lo_nxt;

  assign in_acc     = in_valid_i & (state_q == S_LOAD);
  assign in_stall_o = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;

  always_comb begin
    i_hi     = (k_q < fc_q - 1'b1) ? k_q : fc_q - 1'b1;
    k_max    = fc_q + sc_q - POW_W'(2);
    k_nxt    = k_q + 1'b1;
    i_lo_nxt = (k_nxt >= sc_q) ? k_nxt - sc_q + 1'b1 : '0;
  end

  always_comb begin
    state_d     = state_q;
    fc_d        = fc_q;
    sc_d        = sc_q;
    closed_d    = closed_q;
    k_d         = k_q;
    i_d         = i_q;
    e_d         = e_q;
    elast_d     = elast_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    case (state_q)
      S_LOAD: begin
        cmd_o.wr_addr = operand_i ? sc_q : fc_q;
        if (in_acc && !operand_i && !closed_q) begin
          if (fc_q < MAX_CNT) begin
            cmd_o.wr_a = 1'b1;
            fc_d       = fc_q + 1'b1;
          end
          if (last_i) begin
            closed_d = 1'b1;
          end
        end else if (in_acc && operand_i && closed_q) begin
          if (sc_q < MAX_CNT) begin
            cmd_o.wr_b = 1'b1;
            sc_d       = sc_q + 1'b1;
          end
          if (last_i) begin
            cmd_o.clr_any = 1'b1;
            k_d           = '0;
            i_d           = '0;
            state_d       = S_MAC;
          end
        end
      end

      S_MAC: begin
        cmd_o.mac_en    = 1'b1;
        cmd_o.addr_a    = i_q;
        cmd_o.addr_b    = k_q - i_q;
        cmd_o.mac_first = (i_q == ((k_q >= sc_q) ? k_q - sc_q + 1'b1 : '0));
        cmd_o.mac_last  = (i_q == i_hi);
        cmd_o.mac_pow   = k_q;
        if (i_q == i_hi) begin
          if (k_q == k_max) begin
            state_d = S_DRAIN;
          end else begin
            k_d = k_nxt;
            i_d = i_lo_nxt;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      S_DRAIN: begin
        // wait for the last term to land in the result store
        if (!status_i.busy) begin
          elast_d  = status_i.any ? k_max : '0;
          e_d      = '0;
          fc_d     = '0;
          sc_d     = '0;
          closed_d = 1'b0;
          state_d  = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        cmd_o.res_rd   = 1'b1;
        cmd_o.res_addr = e_q;
        state_d        = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        cmd_o.out_load  = 1'b1;
        cmd_o.out_pow   = e_q;
        cmd_o.out_final = (e_q == elast_q);
        out_valid_d     = 1'b1;
        state_d         = S_EMIT_WT;
      end

      S_EMIT_WT: begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
          if (e_q == elast_q) begin
            state_d = S_LOAD;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fc_q        <= '0;
      sc_q        <= '0;
      closed_q    <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      e_q         <= '0;
      elast_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      sc_q        <= sc_d;
      closed_q    <= closed_d;
      k_q         <= k_d;
      i_q         <= i_d;
      e_q         <= e_d;
      elast_q     <= elast_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== dv/polymul_checker.sv =====
// ----------------------------------------------------------------------------
// polymul_checker
// Watches both channels of the polynomial multiplier and predicts every
// product word from the accepted input words: exact convolution, rounding to
// the fixed-point format and saturation. Each product word is compared, field
// by field, with the oldest prediction. Reports the number of predicted words
// still due and the number of failures.
// ----------------------------------------------------------------------------
module polymul_checker import polymul_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      operand_i,
  input  logic signed [COEFF_W-1:0] coeff_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [COEFF_W-1:0] product_coeff_i,
  input  logic [POW_W-1:0]          power_i,
  input  logic                      saturated_i,
  input  logic                      final_res_i,
  output int unsigned               pending_o,
  output int unsigned               fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for the sum of MAX_TERMS full 64-bit products
  localparam int unsigned ACC_W = 2 * COEFF_W + 16;
  localparam logic signed [ACC_W-1:0] HALF_LSB =
    (FRAC_BITS == 0) ? '0 : (ACC_W'(1) << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] COEFF_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] COEFF_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [POW_W-1:0]          power;
    logic                      sat;
    logic                      fin;
  } prod_word_t;

  logic signed [COEFF_W-1:0] first_terms  [MAX_TERMS];
  logic signed [COEFF_W-1:0] second_terms [MAX_TERMS];
  int unsigned n_first;
  int unsigned n_second;
  bit          first_done;
  prod_word_t  product_q [$];
  int unsigned errors;

  function automatic void predict_product();
    logic signed [ACC_W-1:0] sums [2*MAX_TERMS-1];
    logic signed [ACC_W-1:0] rounded;
    prod_word_t  words [$];
    prod_word_t  w;
    int unsigned nterms;
    bit          nonzero;
    nterms  = n_first + n_second - 1;
    nonzero = 1'b0;
    for (int k = 0; k < 2 * MAX_TERMS - 1; k++) sums[k] = '0;
    for (int i = 0; i < n_first; i++)
      for (int j = 0; j < n_second; j++)
        sums[i+j] = sums[i+j] + first_terms[i] * second_terms[j];
    for (int k = 0; k < nterms; k++) begin
      rounded = sums[k] + HALF_LSB;
      rounded = rounded >>> FRAC_BITS;
      w.power = POW_W'(k);
      w.fin   = (k == nterms - 1);
      if (rounded > COEFF_MAX) begin
        w.coeff = COEFF_MAX[COEFF_W-1:0];
        w.sat   = 1'b1;
      end else if (rounded < COEFF_MIN) begin
        w.coeff = COEFF_MIN[COEFF_W-1:0];
        w.sat   = 1'b1;
      end else begin
        w.coeff = rounded[COEFF_W-1:0];
        w.sat   = 1'b0;
      end
      if (w.coeff != '0) nonzero = 1'b1;
      words.push_back(w);
    end
    // An all-zero product collapses to one zero word of degree 0
    if (!nonzero) begin
      w = '0;
      w.fin = 1'b1;
      product_q.push_back(w);
    end else begin
      foreach (words[k]) product_q.push_back(words[k]);
    end
  endfunction

  function automatic void report_word(string what, prod_word_t want, prod_word_t got);
    if (errors < 10)
      $display("%0t %s: expected coeff %h power %0d sat %b final %b,",
               $realtime, what, want.coeff, want.power, want.sat, want.fin,
               " got coeff %h power %0d sat %b final %b",
               got.coeff, got.power, got.sat, got.fin);
    errors++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prod_word_t got;
    prod_word_t want;
    if (!rst_ni) begin
      n_first    = 0;
      n_second   = 0;
      first_done = 1'b0;
      errors     = 0;
      product_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {product_coeff_i, power_i, saturated_i, final_res_i};
        if (product_q.size() == 0) begin
          report_word("product word with none expected", '0, got);
        end else begin
          want = product_q.pop_front();
          if (got.coeff !== want.coeff || got.power !== want.power ||
              got.sat !== want.sat || got.fin !== want.fin)
            report_word("product word mismatch", want, got);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!operand_i) begin
          // first polynomial: ignore once closed, drop past capacity
          if (!first_done) begin
            if (n_first < MAX_TERMS) begin
              first_terms[n_first] = coeff_i;
              n_first++;
            end
            if (last_i) first_done = 1'b1;
          end
        end else if (first_done) begin
          if (n_second < MAX_TERMS) begin
            second_terms[n_second] = coeff_i;
            n_second++;
          end
          if (last_i) begin
            predict_product();
            n_first    = 0;
            n_second   = 0;
            first_done = 1'b0;
          end
        end
      end
      pending_o    <= product_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== dv/tb_polynomial_multiply.sv =====
// ----------------------------------------------------------------------------
// tb_polynomial_multiply
// Drives pairs of polynomials into the multiplier and checks the products.
// A short directed run covers extreme coefficients, saturation, rounding ties,
// all-zero products and words that the block must ignore; then random pairs,
// mostly short, a few past capacity, run under four idle and stall phases.
// ----------------------------------------------------------------------------
module tb_polynomial_multiply import polymul_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_TERMS      = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned PHASE_WORDS    = 87;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 200;

  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  localparam logic signed [COEFF_W-1:0] COEFF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEFF_W-1:0] COEFF_MIN = 32'sh8000_0000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic                      operand_i   = OP_FIRST;
  logic signed [COEFF_W-1:0] coeff_i     = '0;
  logic                      last_i      = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [COEFF_W-1:0] product_coeff_o;
  logic [POW_W-1:0]          power_o;
  logic                      saturated_o;
  logic                      final_res_o;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned loaded        = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  polynomial_multiply #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operand_i,
    .coeff_i,
    .last_i,
    .out_valid_o,
    .out_stall_i,
    .product_coeff_o,
    .power_o,
    .saturated_o,
    .final_res_o
  );

  polymul_checker #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .operand_i,
    .coeff_i,
    .last_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .product_coeff_i (product_coeff_o),
    .power_i         (power_o),
    .saturated_i     (saturated_o),
    .final_res_i     (final_res_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send_word(logic op, logic signed [COEFF_W-1:0] c, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operand_i  <= op;
    coeff_i    <= c;
    last_i     <= lst;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COEFF_MAX;
      2:       return COEFF_MIN;
      3, 4:    return $urandom_range(131071) - 32'd65536;
      5:       return ($urandom_range(16) - 32'd8) << FRAC_BITS;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(19) == 0) return $urandom_range(MAX_TERMS + 3, MAX_TERMS - 2);
    return $urandom_range(6, 1);
  endfunction

  task automatic send_poly(logic op, int unsigned n, bit zero_fill);
    for (int k = 0; k < n; k++)
      send_word(op, zero_fill ? '0 : rand_coeff(), k == n - 1);
  endtask

  task automatic send_pair(int unsigned n_a, int unsigned n_b);
    bit zero_a;
    zero_a = ($urandom_range(11) == 0);
    // stray words the block must drop
    if ($urandom_range(7) == 0) send_word(OP_SECOND, rand_coeff(), 1'($urandom_range(1)));
    send_poly(OP_FIRST, n_a, zero_a);
    if ($urandom_range(7) == 0) send_word(OP_FIRST, rand_coeff(), 1'($urandom_range(1)));
    send_poly(OP_SECOND, n_b, 1'b0);
    loaded += n_a + n_b;
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_SECOND, 32'sd5, 1'b0);           // first not closed yet: drop
    send_word(OP_FIRST, COEFF_MAX, 1'b0);
    send_word(OP_FIRST, COEFF_MIN, 1'b1);
    send_word(OP_FIRST, 32'sd123, 1'b1);          // first already closed: drop
    send_word(OP_SECOND, COEFF_MAX, 1'b0);
    send_word(OP_SECOND, COEFF_MIN, 1'b1);        // every term clips
    send_word(OP_FIRST, '0, 1'b1);
    send_word(OP_SECOND, '0, 1'b1);               // all-zero product
    send_word(OP_FIRST, 32'sd1, 1'b1);
    send_word(OP_SECOND, 32'sh0000_8000, 1'b1);   // tie rounds up
    send_word(OP_FIRST, 32'sd1, 1'b1);
    send_word(OP_SECOND, 32'shFFFF_8000, 1'b1);   // tie rounds to zero
    send_word(OP_FIRST, 32'shFFFF_FFFF, 1'b0);
    send_word(OP_FIRST, 32'sh0001_0000, 1'b1);
    send_word(OP_SECOND, 32'sh0001_0000, 1'b0);
    send_word(OP_SECOND, 32'sh0001_8000, 1'b0);
    send_word(OP_SECOND, 32'sh7FFF_0000, 1'b1);
    send_word(OP_FIRST, 32'sh0002_0000, 1'b1);
    send_word(OP_SECOND, 32'shFFFF_0000, 1'b1);

    // both operands past capacity: highest degree product term
    send_pair(MAX_TERMS + 2, MAX_TERMS + 1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 83; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      while (loaded < (ph + 1) * PHASE_WORDS) send_pair(pick_len(), pick_len());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
